>>> src/i4c_pkg.sv
// shared types, constants and helpers for the ipv4 / l4 checksum generator
// depends on nothing; used by every module of the block
package i4c_pkg;

    // ip protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // result kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TCP  = 2'd1;
    localparam logic [1:0] KIND_UDP  = 2'd2;
    localparam logic [1:0] KIND_ICMP = 2'd3;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        odd;      // low byte of its 16-bit word
        logic        hdr_en;   // add into header sum
        logic        l4_en;    // add into l4 sum
        logic        addr_en;  // add into address sum
        logic        last;
        logic [7:0]  proto;    // valid with last
        logic [15:0] l4_len;   // valid with last
        logic        trunc;    // valid with last
    } t_word;

    // sums of one finished packet
    typedef struct packed {
        logic [15:0] hdr_sum;
        logic [15:0] l4_sum;
        logic [15:0] addr_sum;
        logic [7:0]  proto;
        logic [15:0] l4_len;
        logic        trunc;
    } t_fin;

    typedef struct packed {
        logic [15:0] hdr_csum;
        logic [15:0] l4_csum;
        logic [1:0]  kind;
        logic        trunc;
    } t_result;

    // 16-bit one's complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

>>> src/i4c_front.sv
// front end: tracks packet offset and ipv4 header fields, classifies each byte
// depends on i4c_pkg
module i4c_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output i4c_pkg::t_word o_word
);

    logic [15:0] r_off;
    logic [5:0]  r_hb;
    logic [15:0] r_tl;
    logic [7:0]  r_proto;

    logic [5:0]  n_hb;
    logic [15:0] n_tl;
    logic [7:0]  n_proto;
    logic [15:0] n_off;
    logic [15:0] hb16;
    logic [15:0] rel;
    logic        acc;
    logic        in_hdr;
    logic        is_field;
    logic        take;

    assign take   = i_valid && !i_full;
    assign o_push = take;

    always_comb begin
        acc     = (r_off < 16'd4) || (r_off < r_tl);
        n_hb    = r_hb;
        n_tl    = r_tl;
        n_proto = r_proto;
        if (acc) begin
            case (r_off)
                16'd0: n_hb = {i_data_byte[3:0], 2'b00};
                16'd2: n_tl = {i_data_byte, r_tl[7:0]};
                16'd3: n_tl = {r_tl[15:8], i_data_byte};
                16'd9: n_proto = i_data_byte;
                default: ;
            endcase
        end
        hb16   = {10'b0, n_hb};
        in_hdr = r_off < hb16;
        rel    = r_off - hb16;
        case (n_proto)
            i4c_pkg::PROTO_TCP:  is_field = (rel == 16'd16) || (rel == 16'd17);
            i4c_pkg::PROTO_UDP:  is_field = (rel == 16'd6) || (rel == 16'd7);
            i4c_pkg::PROTO_ICMP: is_field = (rel == 16'd2) || (rel == 16'd3);
            default:             is_field = 1'b0;
        endcase
        n_off = (r_off == 16'hffff) ? r_off : r_off + 16'd1;

        o_word.data    = i_data_byte;
        o_word.odd     = r_off[0];
        o_word.hdr_en  = acc && in_hdr && (r_off != 16'd10) && (r_off != 16'd11);
        o_word.l4_en   = acc && !in_hdr && (r_off < n_tl) && !is_field;
        o_word.addr_en = acc && (r_off >= 16'd12) && (r_off <= 16'd19);
        o_word.last    = i_last;
        o_word.proto   = n_proto;
        o_word.l4_len  = (n_tl > hb16) ? (n_tl - hb16) : 16'd0;
        o_word.trunc   = (n_off < 16'd4) || (n_off < n_tl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_hb    <= '0;
            r_tl    <= '0;
            r_proto <= '0;
        end else if (take) begin
            if (i_last) begin
                r_off   <= '0;
                r_hb    <= '0;
                r_tl    <= '0;
                r_proto <= '0;
            end else begin
                r_off   <= n_off;
                r_hb    <= n_hb;
                r_tl    <= n_tl;
                r_proto <= n_proto;
            end
        end
    end

endmodule

>>> src/i4c_queue.sv
// small word queue between front and back
// depends on i4c_pkg
module i4c_queue #(
    parameter int DEPTH = i4c_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i4c_pkg::t_word i_word,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output i4c_pkg::t_word o_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i4c_pkg::t_word r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> src/i4c_back.sv
// back end: running one's complement sums, pseudoheader fold and result register
// depends on i4c_pkg
module i4c_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  i4c_pkg::t_word   i_word,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output i4c_pkg::t_result o_result
);

    logic [15:0]      r_hdr;
    logic [15:0]      r_l4;
    logic [15:0]      r_addr;
    logic             r_fin_valid;
    i4c_pkg::t_fin    r_fin;
    logic             r_out_valid;
    i4c_pkg::t_result r_out;

    logic [15:0]      placed;
    logic [15:0]      n_hdr;
    logic [15:0]      n_l4;
    logic [15:0]      n_addr;
    logic             out_free;
    logic             fin_move;
    logic             fin_free;
    logic [17:0]      sum4;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    i4c_pkg::t_result n_out;

    assign out_free = !r_out_valid || !i_stall;
    assign fin_move = r_fin_valid && out_free;
    assign fin_free = !r_fin_valid || fin_move;
    assign o_pop    = i_q_valid && fin_free;

    always_comb begin
        placed = i_word.odd ? {8'h00, i_word.data} : {i_word.data, 8'h00};
        n_hdr  = i_word.hdr_en  ? i4c_pkg::oc_add(r_hdr, placed)  : r_hdr;
        n_l4   = i_word.l4_en   ? i4c_pkg::oc_add(r_l4, placed)   : r_l4;
        n_addr = i_word.addr_en ? i4c_pkg::oc_add(r_addr, placed) : r_addr;
    end

    // pseudoheader plus l4 sum, folded twice
    always_comb begin
        sum4  = {2'b00, r_fin.addr_sum} + {10'b0, r_fin.proto}
              + {2'b00, r_fin.l4_len} + {2'b00, r_fin.l4_sum};
        fold1 = {1'b0, sum4[15:0]} + {15'b0, sum4[17:16]};
        fold2 = fold1[15:0] + {15'b0, fold1[16]};

        n_out.hdr_csum = ~r_fin.hdr_sum;
        n_out.trunc    = r_fin.trunc;
        case (r_fin.proto)
            i4c_pkg::PROTO_TCP: begin
                n_out.kind    = i4c_pkg::KIND_TCP;
                n_out.l4_csum = ~fold2;
            end
            i4c_pkg::PROTO_UDP: begin
                n_out.kind    = i4c_pkg::KIND_UDP;
                n_out.l4_csum = (fold2 == 16'hffff) ? 16'hffff : ~fold2;
            end
            i4c_pkg::PROTO_ICMP: begin
                n_out.kind    = i4c_pkg::KIND_ICMP;
                n_out.l4_csum = ~r_fin.l4_sum;
            end
            default: begin
                n_out.kind    = i4c_pkg::KIND_NONE;
                n_out.l4_csum = 16'h0000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= '0;
            r_l4        <= '0;
            r_addr      <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_word.last) begin
                    r_hdr  <= '0;
                    r_l4   <= '0;
                    r_addr <= '0;
                end else begin
                    r_hdr  <= n_hdr;
                    r_l4   <= n_l4;
                    r_addr <= n_addr;
                end
            end
            if (fin_free) begin
                r_fin_valid <= o_pop && i_word.last;
            end
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_word.last) begin
            r_fin.hdr_sum  <= n_hdr;
            r_fin.l4_sum   <= n_l4;
            r_fin.addr_sum <= n_addr;
            r_fin.proto    <= i_word.proto;
            r_fin.l4_len   <= i_word.l4_len;
            r_fin.trunc    <= i_word.trunc;
        end
        if (fin_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_free |=> r_fin_valid && $stable(r_fin))
        else $error("finished sums lost while output blocked");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == i4c_pkg::KIND_NONE) |-> (r_out.l4_csum == 16'h0000))
        else $error("l4 checksum nonzero with no l4 kind");
    a_udp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == i4c_pkg::KIND_UDP) |-> (r_out.l4_csum != 16'h0000))
        else $error("udp checksum sent as zero");
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_word.last |=> (r_hdr == 16'h0000) && (r_l4 == 16'h0000)
                                 && (r_addr == 16'h0000))
        else $error("running sums not cleared after packet end");
`endif

endmodule

>>> src/ipv4_l4_checksum_generator_top.sv
// top level of the ipv4 header and tcp / udp / icmp checksum generator
// depends on i4c_pkg, i4c_front, i4c_queue, i4c_back
//
// usage
//   input channel: one packet byte per word (i_data_byte) in wire order from
//   the ipv4 version byte, i_last on the final byte; taken when i_valid is
//   high and o_stall is low
//   output channel: one word per packet with the header checksum, the l4
//   checksum, the l4 kind and a truncation flag; taken when o_valid is high
//   and i_stall is low
//   throughput: one byte per cycle while o_stall is low, set by the single
//   end-around-carry adder each running sum goes through in the back end
//   output path: after the last byte is accepted, the queue write, the sum
//   snapshot and the pseudoheader fold into the output register lead to o_valid
//   stall: while the output word waits, the back end holds one more finished
//   packet and the queue keeps filling; o_stall rises only when the queue
//   is full, and o_stall never depends on i_stall in the same cycle
//   reset: synchronous and active low; clears offsets, captured header
//   fields, sums, the queue and both valid flags; any partial packet is lost
module ipv4_l4_checksum_generator_top #(
    parameter int QUEUE_DEPTH = i4c_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ip_header_checksum,
    output logic [15:0] o_l4_checksum,
    output logic [1:0]  o_l4_kind,
    output logic        o_truncated
);

    // front to queue
    logic             push;
    i4c_pkg::t_word   push_word;
    logic             q_full;

    // queue to back
    logic             q_valid;
    logic             q_pop;
    i4c_pkg::t_word   q_word;

    i4c_pkg::t_result result;

    // front never stalls on its own; the queue fill alone backs up the input
    assign o_stall = q_full;

    i4c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_full      (q_full),
        .o_push      (push),
        .o_word      (push_word)
    );

    i4c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    i4c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_word    (q_word),
        .o_pop     (q_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_result  (result)
    );

    // result fields out as separate ports
    assign o_ip_header_checksum = result.hdr_csum;
    assign o_l4_checksum        = result.l4_csum;
    assign o_l4_kind            = result.kind;
    assign o_truncated          = result.trunc;

endmodule
